@@ hw/rtl/mvdc_pkg.sv @@
// ----------------------------------------------------------------------------
// mvdc_pkg
// Shared codes, types and defaults for the vertex delete and compaction block.
// ----------------------------------------------------------------------------
package mvdc_pkg;

    localparam int DEF_MAX_VERTICES  = 1024;
    localparam int DEF_MAX_TRIANGLES = 2048;

    localparam int IDX_W   = 10;   // width of a vertex index field
    localparam int REF_W   = 13;   // reference counter width
    localparam int VCFG_W  = 11;   // vertex_count register width
    localparam int KEPTV_W = 11;
    localparam int KEPTT_W = 12;
    localparam int TRI_W   = 3 * IDX_W + 1;   // dead flag plus three corners

    // Item commands
    localparam logic [2:0] CMD_MARK    = 3'd0;
    localparam logic [2:0] CMD_APPEND  = 3'd1;
    localparam logic [2:0] CMD_COMPUTE = 3'd2;
    localparam logic [2:0] CMD_FETCH   = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_MOVE  = 2'd1;
    localparam logic [1:0] KIND_TRI   = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_CLR_INIT,
        OP_CLR_STEP,
        OP_MARK,
        OP_APPEND,
        OP_P1_INIT,
        OP_SCAN_CLR,
        OP_TREAD,
        OP_TLATCH,
        OP_VREAD_COR,
        OP_VREAD_SCAN,
        OP_TWRITE_DEAD,
        OP_TWRITE_LIVE,
        OP_BUMP,
        OP_VKILL,
        OP_P3_INIT,
        OP_REMAP_W,
        OP_FIN,
        OP_SCAN_CUR,
        OP_CUR_CLR,
        OP_CUR_NEXT,
        OP_FOUND_V,
        OP_FOUND_T,
        OP_RREAD_FOUND,
        OP_RREAD_COR,
        OP_RLATCH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] sel;
        logic       scan_inc;
        logic       emit;
        logic [1:0] kind;
        logic [1:0] err;
        logic       fin;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       mark_oor;
        logic       tri_oor;
        logic       tri_full;
        logic       scan_ge_tot;
        logic       scan_ge_nact;
        logic       cor_oor;
        logic       vdead;
        logic       vref_zero;
        logic       tdead;
        logic       clr_last;
    } dp_status_t;

endpackage

@@ hw/rtl/mvdc_ram.sv @@
// ----------------------------------------------------------------------------
// mvdc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mvdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; read data holds between reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/mvdc_dp.sv @@
// ----------------------------------------------------------------------------
// mvdc_dp
// Datapath: vertex, triangle and remap memories, counters, result registers.
// ----------------------------------------------------------------------------
module mvdc_dp #(
    parameter int MAX_VERTICES  = mvdc_pkg::DEF_MAX_VERTICES,
    parameter int MAX_TRIANGLES = mvdc_pkg::DEF_MAX_TRIANGLES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mvdc_pkg::dp_cmd_t             ctl,
    output mvdc_pkg::dp_status_t          st,
    input  logic                          cfg_wr,
    input  logic [mvdc_pkg::VCFG_W-1:0]   cfg_data,
    input  logic [2:0]                    command,
    input  logic [mvdc_pkg::IDX_W-1:0]    vertex_index,
    input  logic [mvdc_pkg::IDX_W-1:0]    corner_a,
    input  logic [mvdc_pkg::IDX_W-1:0]    corner_b,
    input  logic [mvdc_pkg::IDX_W-1:0]    corner_c,
    output logic                          result_valid,
    output logic [1:0]                    kind,
    output logic [mvdc_pkg::IDX_W-1:0]    old_vertex,
    output logic [mvdc_pkg::IDX_W-1:0]    new_vertex,
    output logic [mvdc_pkg::IDX_W-1:0]    new_corner_a,
    output logic [mvdc_pkg::IDX_W-1:0]    new_corner_b,
    output logic [mvdc_pkg::IDX_W-1:0]    new_corner_c,
    output logic [mvdc_pkg::KEPTV_W-1:0]  kept_vertices,
    output logic [mvdc_pkg::KEPTT_W-1:0]  kept_triangles,
    output logic                          final_item,
    output logic [1:0]                    error
);

    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int TAW = $clog2(MAX_TRIANGLES);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int TCW = $clog2(MAX_TRIANGLES + 1);
    localparam int CW  = (VCW > TCW) ? VCW : TCW;
    localparam int IW  = mvdc_pkg::IDX_W;
    localparam int RW  = mvdc_pkg::REF_W;
    localparam int VW  = RW + 1;

    // Configuration and item registers
    logic [mvdc_pkg::VCFG_W-1:0] vcount_reg;
    logic [2:0]    cmd_reg, cmd_next;
    logic [IW-1:0] vi_reg, vi_next, ca_reg, ca_next, cb_reg, cb_next, cc_reg, cc_next;

    // Working registers
    logic [IW-1:0]  ta_reg, ta_next, tb_reg, tb_next, tc_reg, tc_next;
    logic [IW-1:0]  na_reg, na_next, nb_reg, nb_next, nc_reg, nc_next;
    logic [CW-1:0]  scan_reg, scan_next, cursor_reg, cursor_next, found_reg, found_next;
    logic [TCW-1:0] total_reg, total_next, live_reg, live_next, keptt_reg, keptt_next;
    logic [VCW-1:0] nact_reg, nact_next, k_reg, k_next, keptv_reg, keptv_next;

    // Result registers
    logic          ov_reg, ov_next;
    logic [1:0]    kind_reg, kind_next, err_reg, err_next;
    logic          fin_reg, fin_next;
    logic [IW-1:0] old_reg, old_next, new_reg, new_next;
    logic [IW-1:0] oa_reg, oa_next, ob_reg, ob_next, oc_reg, oc_next;

    // Memory ports
    logic           vwe, vre, twe, tre, rwe, rre;
    logic [VAW-1:0] vwaddr, vraddr, rwaddr, rraddr;
    logic [TAW-1:0] twaddr, traddr;
    logic [VW-1:0]  vwdata, vrdata;
    logic [mvdc_pkg::TRI_W-1:0] twdata, trdata;
    logic [IW-1:0]  rwdata, rrdata;

    logic [VCW-1:0] eff;
    logic [IW-1:0]  cor;
    logic [RW-1:0]  ref_inc;

    mvdc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vram (
        .clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata),
        .re(vre), .raddr(vraddr), .rdata(vrdata)
    );

    mvdc_ram #(.WIDTH(mvdc_pkg::TRI_W), .DEPTH(MAX_TRIANGLES)) u_tram (
        .clk(clk), .we(twe), .waddr(twaddr), .wdata(twdata),
        .re(tre), .raddr(traddr), .rdata(trdata)
    );

    mvdc_ram #(.WIDTH(IW), .DEPTH(MAX_VERTICES)) u_rram (
        .clk(clk), .we(rwe), .waddr(rwaddr), .wdata(rwdata),
        .re(rre), .raddr(rraddr), .rdata(rrdata)
    );

    // Clamp the vertex count to the store size
    always_comb
    begin
        if (32'(vcount_reg) > 32'(MAX_VERTICES))
        begin
            eff = VCW'(MAX_VERTICES);
        end
        else
        begin
            eff = VCW'(vcount_reg);
        end
    end

    // Select the corner under work
    always_comb
    begin
        unique case (ctl.sel)
            2'd0:    cor = ta_reg;
            2'd1:    cor = tb_reg;
            default: cor = tc_reg;
        endcase
    end

    // Saturating reference increment
    assign ref_inc = (vrdata[RW-1:0] == '1) ? vrdata[RW-1:0] : vrdata[RW-1:0] + RW'(1);

    // Status back to the controller
    always_comb
    begin
        st.cmd          = cmd_reg;
        st.mark_oor     = 32'(vi_reg) >= 32'(eff);
        st.tri_oor      = (32'(ca_reg) >= 32'(eff)) || (32'(cb_reg) >= 32'(eff))
                          || (32'(cc_reg) >= 32'(eff));
        st.tri_full     = 32'(total_reg) >= 32'(MAX_TRIANGLES);
        st.scan_ge_tot  = 32'(scan_reg) >= 32'(total_reg);
        st.scan_ge_nact = 32'(scan_reg) >= 32'(nact_reg);
        st.cor_oor      = 32'(cor) >= 32'(nact_reg);
        st.vdead        = vrdata[RW];
        st.vref_zero    = vrdata[RW-1:0] == '0;
        st.tdead        = trdata[mvdc_pkg::TRI_W-1];
        st.clr_last     = 32'(scan_reg) == 32'(MAX_VERTICES - 1);
    end

    // Execute one micro-operation
    always_comb
    begin
        cmd_next    = cmd_reg;
        vi_next     = vi_reg;
        ca_next     = ca_reg;
        cb_next     = cb_reg;
        cc_next     = cc_reg;
        ta_next     = ta_reg;
        tb_next     = tb_reg;
        tc_next     = tc_reg;
        na_next     = na_reg;
        nb_next     = nb_reg;
        nc_next     = nc_reg;
        scan_next   = ctl.scan_inc ? scan_reg + CW'(1) : scan_reg;
        cursor_next = cursor_reg;
        found_next  = found_reg;
        total_next  = total_reg;
        live_next   = live_reg;
        keptt_next  = keptt_reg;
        nact_next   = nact_reg;
        k_next      = k_reg;
        keptv_next  = keptv_reg;
        vwe    = 1'b0;
        vre    = 1'b0;
        twe    = 1'b0;
        tre    = 1'b0;
        rwe    = 1'b0;
        rre    = 1'b0;
        vwaddr = VAW'(cor);
        vraddr = VAW'(cor);
        vwdata = '0;
        twaddr = TAW'(scan_reg);
        traddr = TAW'(scan_reg);
        twdata = {1'b0, ta_reg, tb_reg, tc_reg};
        rwaddr = VAW'(scan_reg);
        rraddr = VAW'(cor);
        rwdata = IW'(k_reg);

        unique case (ctl.op)
            mvdc_pkg::OP_LATCH:
            begin
                cmd_next = command;
                vi_next  = vertex_index;
                ca_next  = corner_a;
                cb_next  = corner_b;
                cc_next  = corner_c;
            end
            mvdc_pkg::OP_CLR_INIT:
            begin
                scan_next   = '0;
                total_next  = '0;
                keptv_next  = '0;
                keptt_next  = '0;
                cursor_next = '0;
            end
            mvdc_pkg::OP_CLR_STEP:
            begin
                vwe    = 1'b1;
                vwaddr = VAW'(scan_reg);
                vwdata = '0;
            end
            mvdc_pkg::OP_MARK:
            begin
                vwe    = 1'b1;
                vwaddr = VAW'(vi_reg);
                vwdata = {1'b1, {RW{1'b0}}};
            end
            mvdc_pkg::OP_APPEND:
            begin
                twe        = 1'b1;
                twaddr     = TAW'(total_reg);
                twdata     = {1'b0, ca_reg, cb_reg, cc_reg};
                total_next = total_reg + TCW'(1);
            end
            mvdc_pkg::OP_P1_INIT:
            begin
                scan_next = '0;
                live_next = '0;
                nact_next = eff;
            end
            mvdc_pkg::OP_SCAN_CLR:
            begin
                scan_next = '0;
            end
            mvdc_pkg::OP_TREAD:
            begin
                tre = 1'b1;
            end
            mvdc_pkg::OP_TLATCH:
            begin
                ta_next = trdata[3*IW-1:2*IW];
                tb_next = trdata[2*IW-1:IW];
                tc_next = trdata[IW-1:0];
            end
            mvdc_pkg::OP_VREAD_COR:
            begin
                vre = 1'b1;
            end
            mvdc_pkg::OP_VREAD_SCAN:
            begin
                vre    = 1'b1;
                vraddr = VAW'(scan_reg);
            end
            mvdc_pkg::OP_TWRITE_DEAD:
            begin
                twe    = 1'b1;
                twdata = {1'b1, ta_reg, tb_reg, tc_reg};
            end
            mvdc_pkg::OP_TWRITE_LIVE:
            begin
                twe       = 1'b1;
                live_next = live_reg + TCW'(1);
            end
            mvdc_pkg::OP_BUMP:
            begin
                vwe    = 1'b1;
                vwdata = {vrdata[RW], ref_inc};
            end
            mvdc_pkg::OP_VKILL:
            begin
                vwe    = 1'b1;
                vwdata = {1'b1, vrdata[RW-1:0]};
            end
            mvdc_pkg::OP_P3_INIT:
            begin
                scan_next = '0;
                k_next    = '0;
            end
            mvdc_pkg::OP_REMAP_W:
            begin
                rwe    = 1'b1;
                k_next = k_reg + VCW'(1);
            end
            mvdc_pkg::OP_FIN:
            begin
                keptv_next  = k_reg;
                keptt_next  = live_reg;
                cursor_next = '0;
            end
            mvdc_pkg::OP_SCAN_CUR:
            begin
                scan_next = cursor_reg;
            end
            mvdc_pkg::OP_CUR_CLR:
            begin
                cursor_next = '0;
            end
            mvdc_pkg::OP_CUR_NEXT:
            begin
                cursor_next = found_reg + CW'(1);
            end
            mvdc_pkg::OP_FOUND_V:
            begin
                found_next = scan_reg;
            end
            mvdc_pkg::OP_FOUND_T:
            begin
                found_next = scan_reg;
                ta_next    = trdata[3*IW-1:2*IW];
                tb_next    = trdata[2*IW-1:IW];
                tc_next    = trdata[IW-1:0];
            end
            mvdc_pkg::OP_RREAD_FOUND:
            begin
                rre    = 1'b1;
                rraddr = VAW'(found_reg);
            end
            mvdc_pkg::OP_RREAD_COR:
            begin
                rre = 1'b1;
            end
            mvdc_pkg::OP_RLATCH:
            begin
                unique case (ctl.sel)
                    2'd0:    na_next = rrdata;
                    2'd1:    nb_next = rrdata;
                    default: nc_next = rrdata;
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // Build the result
    always_comb
    begin
        ov_next   = ctl.emit;
        kind_next = kind_reg;
        err_next  = err_reg;
        fin_next  = fin_reg;
        old_next  = old_reg;
        new_next  = new_reg;
        oa_next   = oa_reg;
        ob_next   = ob_reg;
        oc_next   = oc_reg;
        if (ctl.emit)
        begin
            kind_next = ctl.kind;
            err_next  = ctl.err;
            fin_next  = ctl.fin;
            old_next  = (ctl.kind == mvdc_pkg::KIND_MOVE) ? IW'(found_reg) : '0;
            new_next  = (ctl.kind == mvdc_pkg::KIND_MOVE) ? rrdata : '0;
            oa_next   = (ctl.kind == mvdc_pkg::KIND_TRI) ? na_reg : '0;
            ob_next   = (ctl.kind == mvdc_pkg::KIND_TRI) ? nb_reg : '0;
            oc_next   = (ctl.kind == mvdc_pkg::KIND_TRI) ? nc_reg : '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
            scan_reg   <= '0;
            cursor_reg <= '0;
            total_reg  <= '0;
            keptv_reg  <= '0;
            keptt_reg  <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                vcount_reg <= cfg_data;
            end
            scan_reg   <= scan_next;
            cursor_reg <= cursor_next;
            total_reg  <= total_next;
            keptv_reg  <= keptv_next;
            keptt_reg  <= keptt_next;
            ov_reg     <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        vi_reg    <= vi_next;
        ca_reg    <= ca_next;
        cb_reg    <= cb_next;
        cc_reg    <= cc_next;
        ta_reg    <= ta_next;
        tb_reg    <= tb_next;
        tc_reg    <= tc_next;
        na_reg    <= na_next;
        nb_reg    <= nb_next;
        nc_reg    <= nc_next;
        found_reg <= found_next;
        live_reg  <= live_next;
        nact_reg  <= nact_next;
        k_reg     <= k_next;
        kind_reg  <= kind_next;
        err_reg   <= err_next;
        fin_reg   <= fin_next;
        old_reg   <= old_next;
        new_reg   <= new_next;
        oa_reg    <= oa_next;
        ob_reg    <= ob_next;
        oc_reg    <= oc_next;
    end

    assign result_valid   = ov_reg;
    assign kind           = kind_reg;
    assign old_vertex     = old_reg;
    assign new_vertex     = new_reg;
    assign new_corner_a   = oa_reg;
    assign new_corner_b   = ob_reg;
    assign new_corner_c   = oc_reg;
    assign kept_vertices  = mvdc_pkg::KEPTV_W'(keptv_reg);
    assign kept_triangles = mvdc_pkg::KEPTT_W'(keptt_reg);
    assign final_item     = fin_reg;
    assign error          = err_reg;

endmodule

@@ hw/rtl/mvdc_ctrl.sv @@
// ----------------------------------------------------------------------------
// mvdc_ctrl
// Controller: decodes items and sequences clear, compute and fetch walks.
// ----------------------------------------------------------------------------
module mvdc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  mvdc_pkg::dp_status_t st,
    output mvdc_pkg::dp_cmd_t    ctl
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISP,
        S_P1_T, S_P1_TL, S_P1_CRD, S_P1_CCK, S_P1_DEC, S_P1_BRD, S_P1_BWR,
        S_P2_T, S_P2_TL, S_P2_CRD, S_P2_CCK,
        S_P3_V, S_P3_CK,
        S_MV_A, S_MV_AC, S_MV_B, S_MV_BC, S_MV_R, S_MV_E,
        S_TR_S0, S_TR_A, S_TR_AC, S_TR_B, S_TR_BC, S_TR_R, S_TR_L, S_TR_E
    } state_t;

    typedef enum logic [1:0] {
        PH_LOAD, PH_MOVES, PH_TRIS, PH_DONE
    } phase_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] sel_reg, sel_next;
    logic       dead_reg, dead_next;
    logic       fin_reg, fin_next;
    logic       ackp_reg, ackp_next;

    assign busy = state_reg != S_IDLE;

    // Next state and datapath command
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        sel_next     = sel_reg;
        dead_next    = dead_reg;
        fin_next     = fin_reg;
        ackp_next    = ackp_reg;
        ctl.op       = mvdc_pkg::OP_NONE;
        ctl.sel      = sel_reg;
        ctl.scan_inc = 1'b0;
        ctl.emit     = 1'b0;
        ctl.kind     = mvdc_pkg::KIND_ACK;
        ctl.err      = mvdc_pkg::ERR_NONE;
        ctl.fin      = 1'b0;

        unique case (state_reg)
            // Sweep the vertex memory to zero
            S_CLR:
            begin
                ctl.op       = mvdc_pkg::OP_CLR_STEP;
                ctl.scan_inc = 1'b1;
                if (st.clr_last)
                begin
                    ctl.emit   = ackp_reg;
                    ackp_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ctl.op = mvdc_pkg::OP_LATCH;
                if (start)
                begin
                    state_next = S_DISP;
                end
            end
            // Decode the item
            S_DISP:
            begin
                state_next = S_IDLE;
                unique case (st.cmd)
                    mvdc_pkg::CMD_MARK:
                    begin
                        ctl.emit = 1'b1;
                        if (phase_reg == PH_LOAD)
                        begin
                            if (st.mark_oor)
                            begin
                                ctl.err = mvdc_pkg::ERR_RANGE;
                            end
                            else
                            begin
                                ctl.op = mvdc_pkg::OP_MARK;
                            end
                        end
                    end
                    mvdc_pkg::CMD_APPEND:
                    begin
                        ctl.emit = 1'b1;
                        if (phase_reg == PH_LOAD)
                        begin
                            priority if (st.tri_oor)
                            begin
                                ctl.err = mvdc_pkg::ERR_RANGE;
                            end
                            else if (st.tri_full)
                            begin
                                ctl.err = mvdc_pkg::ERR_FULL;
                            end
                            else
                            begin
                                ctl.op = mvdc_pkg::OP_APPEND;
                            end
                        end
                    end
                    mvdc_pkg::CMD_COMPUTE:
                    begin
                        if (phase_reg == PH_LOAD)
                        begin
                            ctl.op     = mvdc_pkg::OP_P1_INIT;
                            state_next = S_P1_T;
                        end
                        else
                        begin
                            ctl.emit = 1'b1;
                        end
                    end
                    mvdc_pkg::CMD_FETCH:
                    begin
                        unique case (phase_reg)
                            PH_MOVES:
                            begin
                                ctl.op     = mvdc_pkg::OP_SCAN_CUR;
                                state_next = S_MV_A;
                            end
                            PH_TRIS:
                            begin
                                ctl.op     = mvdc_pkg::OP_SCAN_CUR;
                                state_next = S_TR_A;
                            end
                            default:
                            begin
                                ctl.emit = 1'b1;
                                ctl.kind = mvdc_pkg::KIND_EMPTY;
                            end
                        endcase
                    end
                    mvdc_pkg::CMD_CLEAR:
                    begin
                        ctl.op     = mvdc_pkg::OP_CLR_INIT;
                        phase_next = PH_LOAD;
                        ackp_next  = 1'b1;
                        state_next = S_CLR;
                    end
                    default:
                    begin
                        ctl.emit = 1'b1;
                    end
                endcase
            end
            // Pass 1: drop triangles and count references
            S_P1_T:
            begin
                if (st.scan_ge_tot)
                begin
                    ctl.op     = mvdc_pkg::OP_SCAN_CLR;
                    state_next = S_P2_T;
                end
                else
                begin
                    ctl.op     = mvdc_pkg::OP_TREAD;
                    state_next = S_P1_TL;
                end
            end
            S_P1_TL:
            begin
                ctl.op     = mvdc_pkg::OP_TLATCH;
                sel_next   = 2'd0;
                dead_next  = 1'b0;
                state_next = S_P1_CRD;
            end
            S_P1_CRD:
            begin
                if (st.cor_oor)
                begin
                    dead_next  = 1'b1;
                    state_next = S_P1_DEC;
                end
                else
                begin
                    ctl.op     = mvdc_pkg::OP_VREAD_COR;
                    state_next = S_P1_CCK;
                end
            end
            S_P1_CCK:
            begin
                if (st.vdead)
                begin
                    dead_next  = 1'b1;
                    state_next = S_P1_DEC;
                end
                else if (sel_reg == 2'd2)
                begin
                    state_next = S_P1_DEC;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_P1_CRD;
                end
            end
            S_P1_DEC:
            begin
                if (dead_reg)
                begin
                    ctl.op       = mvdc_pkg::OP_TWRITE_DEAD;
                    ctl.scan_inc = 1'b1;
                    state_next   = S_P1_T;
                end
                else
                begin
                    ctl.op     = mvdc_pkg::OP_TWRITE_LIVE;
                    sel_next   = 2'd0;
                    state_next = S_P1_BRD;
                end
            end
            S_P1_BRD:
            begin
                ctl.op     = mvdc_pkg::OP_VREAD_COR;
                state_next = S_P1_BWR;
            end
            S_P1_BWR:
            begin
                ctl.op = mvdc_pkg::OP_BUMP;
                if (sel_reg == 2'd2)
                begin
                    ctl.scan_inc = 1'b1;
                    state_next   = S_P1_T;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_P1_BRD;
                end
            end
            // Pass 2: delete free corners of dropped triangles
            S_P2_T:
            begin
                if (st.scan_ge_tot)
                begin
                    ctl.op     = mvdc_pkg::OP_P3_INIT;
                    state_next = S_P3_V;
                end
                else
                begin
                    ctl.op     = mvdc_pkg::OP_TREAD;
                    state_next = S_P2_TL;
                end
            end
            S_P2_TL:
            begin
                ctl.op   = mvdc_pkg::OP_TLATCH;
                sel_next = 2'd0;
                if (st.tdead)
                begin
                    state_next = S_P2_CRD;
                end
                else
                begin
                    ctl.scan_inc = 1'b1;
                    state_next   = S_P2_T;
                end
            end
            S_P2_CRD, S_P2_CCK:
            begin
                if (state_reg == S_P2_CRD && !st.cor_oor)
                begin
                    ctl.op     = mvdc_pkg::OP_VREAD_COR;
                    state_next = S_P2_CCK;
                end
                else
                begin
                    if (state_reg == S_P2_CCK && !st.vdead && st.vref_zero)
                    begin
                        ctl.op = mvdc_pkg::OP_VKILL;
                    end
                    if (sel_reg == 2'd2)
                    begin
                        ctl.scan_inc = 1'b1;
                        state_next   = S_P2_T;
                    end
                    else
                    begin
                        sel_next   = sel_reg + 2'd1;
                        state_next = S_P2_CRD;
                    end
                end
            end
            // Pass 3: number the kept vertices
            S_P3_V:
            begin
                if (st.scan_ge_nact)
                begin
                    ctl.op     = mvdc_pkg::OP_FIN;
                    ctl.emit   = 1'b1;
                    phase_next = PH_MOVES;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.op     = mvdc_pkg::OP_VREAD_SCAN;
                    state_next = S_P3_CK;
                end
            end
            S_P3_CK:
            begin
                if (!st.vdead)
                begin
                    ctl.op = mvdc_pkg::OP_REMAP_W;
                end
                ctl.scan_inc = 1'b1;
                state_next   = S_P3_V;
            end
            // Fetch a vertex move and look ahead for the last one
            S_MV_A:
            begin
                if (st.scan_ge_nact)
                begin
                    ctl.op     = mvdc_pkg::OP_CUR_CLR;
                    phase_next = PH_TRIS;
                    state_next = S_TR_S0;
                end
                else
                begin
                    ctl.op     = mvdc_pkg::OP_VREAD_SCAN;
                    state_next = S_MV_AC;
                end
            end
            S_MV_AC:
            begin
                ctl.scan_inc = 1'b1;
                if (st.vdead)
                begin
                    state_next = S_MV_A;
                end
                else
                begin
                    ctl.op     = mvdc_pkg::OP_FOUND_V;
                    state_next = S_MV_B;
                end
            end
            S_MV_B:
            begin
                if (st.scan_ge_nact)
                begin
                    fin_next   = 1'b1;
                    state_next = S_MV_R;
                end
                else
                begin
                    ctl.op     = mvdc_pkg::OP_VREAD_SCAN;
                    state_next = S_MV_BC;
                end
            end
            S_MV_BC:
            begin
                if (st.vdead)
                begin
                    ctl.scan_inc = 1'b1;
                    state_next   = S_MV_B;
                end
                else
                begin
                    fin_next   = 1'b0;
                    state_next = S_MV_R;
                end
            end
            S_MV_R:
            begin
                ctl.op     = mvdc_pkg::OP_RREAD_FOUND;
                state_next = S_MV_E;
            end
            S_MV_E:
            begin
                ctl.emit   = 1'b1;
                ctl.kind   = mvdc_pkg::KIND_MOVE;
                ctl.fin    = fin_reg;
                state_next = S_IDLE;
                if (fin_reg)
                begin
                    ctl.op     = mvdc_pkg::OP_CUR_CLR;
                    phase_next = PH_TRIS;
                end
                else
                begin
                    ctl.op = mvdc_pkg::OP_CUR_NEXT;
                end
            end
            // Fetch a surviving triangle and look ahead for the last one
            S_TR_S0:
            begin
                ctl.op     = mvdc_pkg::OP_SCAN_CUR;
                state_next = S_TR_A;
            end
            S_TR_A:
            begin
                if (st.scan_ge_tot)
                begin
                    ctl.emit   = 1'b1;
                    ctl.kind   = mvdc_pkg::KIND_EMPTY;
                    phase_next = PH_DONE;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.op     = mvdc_pkg::OP_TREAD;
                    state_next = S_TR_AC;
                end
            end
            S_TR_AC:
            begin
                ctl.scan_inc = 1'b1;
                if (st.tdead)
                begin
                    state_next = S_TR_A;
                end
                else
                begin
                    ctl.op     = mvdc_pkg::OP_FOUND_T;
                    sel_next   = 2'd0;
                    state_next = S_TR_B;
                end
            end
            S_TR_B:
            begin
                if (st.scan_ge_tot)
                begin
                    fin_next   = 1'b1;
                    state_next = S_TR_R;
                end
                else
                begin
                    ctl.op     = mvdc_pkg::OP_TREAD;
                    state_next = S_TR_BC;
                end
            end
            S_TR_BC:
            begin
                if (st.tdead)
                begin
                    ctl.scan_inc = 1'b1;
                    state_next   = S_TR_B;
                end
                else
                begin
                    fin_next   = 1'b0;
                    state_next = S_TR_R;
                end
            end
            S_TR_R:
            begin
                ctl.op     = mvdc_pkg::OP_RREAD_COR;
                state_next = S_TR_L;
            end
            S_TR_L:
            begin
                ctl.op = mvdc_pkg::OP_RLATCH;
                if (sel_reg == 2'd2)
                begin
                    state_next = S_TR_E;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_TR_R;
                end
            end
            S_TR_E:
            begin
                ctl.emit   = 1'b1;
                ctl.kind   = mvdc_pkg::KIND_TRI;
                ctl.fin    = fin_reg;
                state_next = S_IDLE;
                if (fin_reg)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    ctl.op = mvdc_pkg::OP_CUR_NEXT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            phase_reg <= PH_LOAD;
            sel_reg   <= 2'd0;
            dead_reg  <= 1'b0;
            fin_reg   <= 1'b0;
            ackp_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            sel_reg   <= sel_next;
            dead_reg  <= dead_next;
            fin_reg   <= fin_next;
            ackp_reg  <= ackp_next;
        end
    end

endmodule

@@ hw/rtl/mesh_vertex_delete_compact.sv @@
// ----------------------------------------------------------------------------
// mesh_vertex_delete_compact
// Deletes marked vertices from a triangle mesh and returns the compacted mesh.
// ----------------------------------------------------------------------------
// Every accepted item gives exactly one result, shown for one cycle with
// result_valid; the receiver cannot stall it. Mark, append and unknown items
// are decoded in the dispatch state and their result is registered. After
// reset and after a clear the block sweeps the whole vertex memory, one
// entry a cycle, with busy high. Compute walks the triangle store twice and
// the vertex memory once over single-port reads. A fetch scans dead flags
// from its cursor up to the kept entry after the one returned.
module mesh_vertex_delete_compact #(
    parameter int MAX_VERTICES  = mvdc_pkg::DEF_MAX_VERTICES,
    parameter int MAX_TRIANGLES = mvdc_pkg::DEF_MAX_TRIANGLES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    command,
    input  logic [mvdc_pkg::IDX_W-1:0]    vertex_index,
    input  logic [mvdc_pkg::IDX_W-1:0]    corner_a,
    input  logic [mvdc_pkg::IDX_W-1:0]    corner_b,
    input  logic [mvdc_pkg::IDX_W-1:0]    corner_c,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mvdc_pkg::VCFG_W-1:0]   cfg_data,
    output logic                          result_valid,
    output logic [1:0]                    kind,
    output logic [mvdc_pkg::IDX_W-1:0]    old_vertex,
    output logic [mvdc_pkg::IDX_W-1:0]    new_vertex,
    output logic [mvdc_pkg::IDX_W-1:0]    new_corner_a,
    output logic [mvdc_pkg::IDX_W-1:0]    new_corner_b,
    output logic [mvdc_pkg::IDX_W-1:0]    new_corner_c,
    output logic [mvdc_pkg::KEPTV_W-1:0]  kept_vertices,
    output logic [mvdc_pkg::KEPTT_W-1:0]  kept_triangles,
    output logic                          final_item,
    output logic [1:0]                    error
);

    mvdc_pkg::dp_cmd_t    ctl;
    mvdc_pkg::dp_status_t st;

    // Configuration is written only while idle
    assign cfg_ready = !busy;

    mvdc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .st    (st),
        .ctl   (ctl)
    );

    mvdc_dp #(
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .st             (st),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .command        (command),
        .vertex_index   (vertex_index),
        .corner_a       (corner_a),
        .corner_b       (corner_b),
        .corner_c       (corner_c),
        .result_valid   (result_valid),
        .kind           (kind),
        .old_vertex     (old_vertex),
        .new_vertex     (new_vertex),
        .new_corner_a   (new_corner_a),
        .new_corner_b   (new_corner_b),
        .new_corner_c   (new_corner_c),
        .kept_vertices  (kept_vertices),
        .kept_triangles (kept_triangles),
        .final_item     (final_item),
        .error          (error)
    );

    // An accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepting an item");

    // Results never come in consecutive cycles
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for two cycles");

    // Move fields are zero unless a move is reported
    a_move_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind != mvdc_pkg::KIND_MOVE |-> old_vertex == '0 && new_vertex == '0)
        else $error("move fields set on a non-move result");

    // Last-item flag only on moves and triangles
    a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && final_item |->
            kind == mvdc_pkg::KIND_MOVE || kind == mvdc_pkg::KIND_TRI)
        else $error("final_item on a result that is no move or triangle");

endmodule
